// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the core, clocked on clk, reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge outside reset.
`define SCSF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define SCSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/scsf_pkg.sv
// ----------------------------------------------------------------------------
// scsf_pkg
// Opcodes, register indexes and port widths of the scanline seed fill core.
// ----------------------------------------------------------------------------
package scsf_pkg;

    // Input item kinds (s_tuser)
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_FILL_COLOR    = 2'd0;
    localparam logic [1:0] REG_ACTIVE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_ACTIVE_HEIGHT = 2'd2;

    // Port widths
    localparam int COORD_W     = 8;
    localparam int PIX_PORT_W  = 32;
    localparam int DIM_W       = 9;
    localparam int S_TDATA_W   = 48;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 40;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

endpackage

// File: rtl/core/scsf_ram.sv
// ----------------------------------------------------------------------------
// scsf_ram
// Simple dual-port synchronous RAM: one write port, one read port, read data
// registered and held while no read is issued.
// ----------------------------------------------------------------------------
module scsf_ram #(
    parameter int AW = 16,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/scsf_fill_engine.sv
// ----------------------------------------------------------------------------
// scsf_fill_engine
// Item sequencer: pixel writes and reads, and the stack walk of a seed fill
// (pop, paint left, paint right, scan the rows above and below), with the
// result output register.
// ----------------------------------------------------------------------------
module scsf_fill_engine #(
    parameter int XW          = 8,
    parameter int YW          = 8,
    parameter int PIXEL_BITS  = 32,
    parameter int STACK_DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [scsf_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [scsf_pkg::S_TUSER_W-1:0]   s_tuser,
    // output stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [scsf_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tuser,
    // window and color
    input  logic [PIXEL_BITS-1:0]            fill_color,
    input  logic [XW:0]                      win_w,
    input  logic [YW:0]                      win_h,
    // frame memory
    output logic                             frame_we,
    output logic [YW+XW-1:0]                 frame_waddr,
    output logic [PIXEL_BITS-1:0]            frame_wdata,
    output logic                             frame_re,
    output logic [YW+XW-1:0]                 frame_raddr,
    input  logic [PIXEL_BITS-1:0]            frame_rdata,
    // seed stack memory
    output logic                             stack_we,
    output logic [$clog2(STACK_DEPTH)-1:0]   stack_waddr,
    output logic [YW+XW-1:0]                 stack_wdata,
    output logic                             stack_re,
    output logic [$clog2(STACK_DEPTH)-1:0]   stack_raddr,
    input  logic [YW+XW-1:0]                 stack_rdata,
    // status
    output logic [$clog2(STACK_DEPTH+1)-1:0] stack_level
);

    import scsf_pkg::*;

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int LW  = $clog2(STACK_DEPTH + 1);
    localparam int CXW = (XW + 1 > COORD_W) ? XW + 1 : COORD_W;
    localparam int CYW = (YW + 1 > COORD_W) ? YW + 1 : COORD_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_POP,
        ST_POP_WAIT,
        ST_LEFT,
        ST_RIGHT,
        ST_NEXT_ROW,
        ST_SCAN
    } state_t;

    state_t                state_reg, state_next;
    logic [XW:0]           cur_reg, cur_next;
    logic [XW-1:0]         seed_x_reg, seed_x_next;
    logic [YW-1:0]         row_reg, row_next;
    logic [YW-1:0]         scan_y_reg, scan_y_next;
    logic [XW:0]           lo_reg, lo_next;
    logic [XW-1:0]         hi_reg, hi_next;
    logic                  below_reg, below_next;
    logic                  prev_edge_reg, prev_edge_next;
    logic                  done_pend_reg, done_pend_next;
    logic [LW-1:0]         level_reg, level_next;
    logic                  ovf_reg, ovf_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [PIX_PORT_W-1:0] m_pix_reg, m_pix_next;
    logic                  m_done_reg, m_done_next;
    logic                  m_ovf_reg, m_ovf_next;

    // Input item fields
    logic [COORD_W-1:0]    in_x, in_y;
    logic [PIX_PORT_W-1:0] in_pix;
    logic                  in_inside;
    logic                  out_free;
    logic                  accept;

    // Working variables
    logic                  start_right;
    logic [XW:0]           right_first;
    logic                  push_en;
    logic [XW-1:0]         push_x;
    logic [YW-1:0]         push_y;
    logic                  edge_hit;

    assign in_x      = s_tdata[COORD_W-1:0];
    assign in_y      = s_tdata[2*COORD_W-1:COORD_W];
    assign in_pix    = s_tdata[2*COORD_W+PIX_PORT_W-1:2*COORD_W];
    assign in_inside = (CXW'(in_x) < CXW'(win_w)) && (CYW'(in_y) < CYW'(win_h));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && !done_pend_reg && out_free;
    assign accept    = s_tvalid && s_tready;
    assign edge_hit  = (frame_rdata == fill_color);
    assign right_first = {1'b0, seed_x_reg} + 1'b1;

    assign m_tvalid    = m_tvalid_reg;
    assign m_tdata     = {{(M_TDATA_W-PIX_PORT_W-1){1'b0}}, m_ovf_reg, m_pix_reg};
    assign m_tuser     = m_done_reg;
    assign stack_level = level_reg;

    // Stack level a push lands on: a fill beat starts from an empty stack
    function automatic logic [LW-1:0] level_next_base();
        logic [LW-1:0] lv;
        lv = (state_reg == ST_IDLE) ? '0 : level_reg;
        return lv;
    endfunction

    // Next-state and memory control
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        seed_x_next    = seed_x_reg;
        row_next       = row_reg;
        scan_y_next    = scan_y_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        below_next     = below_reg;
        prev_edge_next = prev_edge_reg;
        done_pend_next = done_pend_reg;
        level_next     = level_reg;
        ovf_next       = ovf_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_pix_next     = m_pix_reg;
        m_done_next    = m_done_reg;
        m_ovf_next     = m_ovf_reg;

        frame_we    = 1'b0;
        frame_waddr = {row_reg, cur_reg[XW-1:0]};
        frame_wdata = fill_color;
        frame_re    = 1'b0;
        frame_raddr = {row_reg, cur_reg[XW-1:0]};
        stack_re    = 1'b0;
        stack_raddr = SAW'(level_reg - 1'b1);

        start_right = 1'b0;
        push_en     = 1'b0;
        push_x      = cur_reg[XW-1:0];
        push_y      = scan_y_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (done_pend_reg)
                begin
                    // fill result waits for the output register
                    if (out_free)
                    begin
                        m_tvalid_next  = 1'b1;
                        m_pix_next     = '0;
                        m_done_next    = 1'b1;
                        m_ovf_next     = ovf_reg;
                        done_pend_next = 1'b0;
                    end
                end
                else if (accept)
                begin
                    unique case (s_tuser)
                        OP_WRITE:
                        begin
                            frame_we    = in_inside;
                            frame_waddr = {YW'(in_y), XW'(in_x)};
                            frame_wdata = in_pix[PIXEL_BITS-1:0];
                        end
                        OP_READ:
                        begin
                            if (in_inside)
                            begin
                                frame_re    = 1'b1;
                                frame_raddr = {YW'(in_y), XW'(in_x)};
                                state_next  = ST_READ;
                            end
                            else
                            begin
                                m_tvalid_next = 1'b1;
                                m_pix_next    = '0;
                                m_done_next   = 1'b0;
                                m_ovf_next    = 1'b0;
                            end
                        end
                        OP_FILL:
                        begin
                            ovf_next   = 1'b0;
                            level_next = '0;
                            if (in_inside)
                            begin
                                push_en    = 1'b1;
                                push_x     = XW'(in_x);
                                push_y     = YW'(in_y);
                                state_next = ST_POP;
                            end
                            else
                            begin
                                done_pend_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_pix_next    = PIX_PORT_W'(frame_rdata);
                    m_done_next   = 1'b0;
                    m_ovf_next    = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            ST_POP:
            begin
                if (level_reg == '0)
                begin
                    done_pend_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    stack_re   = 1'b1;
                    level_next = level_reg - 1'b1;
                    state_next = ST_POP_WAIT;
                end
            end

            ST_POP_WAIT:
            begin
                seed_x_next = stack_rdata[XW-1:0];
                row_next    = stack_rdata[YW+XW-1:XW];
                cur_next    = {1'b0, stack_rdata[XW-1:0]};
                frame_re    = 1'b1;
                frame_raddr = stack_rdata;
                state_next  = ST_LEFT;
            end

            // paint leftward from the seed
            ST_LEFT:
            begin
                if (!edge_hit)
                begin
                    frame_we = 1'b1;
                    if (cur_reg == '0)
                    begin
                        lo_next     = '0;
                        start_right = 1'b1;
                    end
                    else
                    begin
                        cur_next    = cur_reg - 1'b1;
                        frame_re    = 1'b1;
                        frame_raddr = {row_reg, XW'(cur_reg - 1'b1)};
                    end
                end
                else
                begin
                    lo_next     = cur_reg + 1'b1;
                    start_right = 1'b1;
                end
            end

            // paint rightward from the pixel after the seed
            ST_RIGHT:
            begin
                if (!edge_hit)
                begin
                    frame_we = 1'b1;
                    if ((cur_reg + 1'b1) >= win_w)
                    begin
                        hi_next    = cur_reg[XW-1:0];
                        below_next = 1'b0;
                        state_next = ST_NEXT_ROW;
                    end
                    else
                    begin
                        cur_next    = cur_reg + 1'b1;
                        frame_re    = 1'b1;
                        frame_raddr = {row_reg, XW'(cur_reg + 1'b1)};
                    end
                end
                else
                begin
                    hi_next    = XW'(cur_reg - 1'b1);
                    below_next = 1'b0;
                    state_next = ST_NEXT_ROW;
                end
            end

            // pick the next neighbor row to scan
            ST_NEXT_ROW:
            begin
                cur_next       = lo_reg;
                prev_edge_next = 1'b1;
                if (lo_reg > {1'b0, hi_reg})
                begin
                    state_next = ST_POP;
                end
                else if (!below_reg)
                begin
                    if (row_reg != '0)
                    begin
                        scan_y_next = row_reg - 1'b1;
                        frame_re    = 1'b1;
                        frame_raddr = {YW'(row_reg - 1'b1), lo_reg[XW-1:0]};
                        state_next  = ST_SCAN;
                    end
                    else
                    begin
                        below_next = 1'b1;
                    end
                end
                else if (({1'b0, row_reg} + 1'b1) < win_h)
                begin
                    scan_y_next = row_reg + 1'b1;
                    frame_re    = 1'b1;
                    frame_raddr = {YW'(row_reg + 1'b1), lo_reg[XW-1:0]};
                    state_next  = ST_SCAN;
                end
                else
                begin
                    state_next = ST_POP;
                end
            end

            // scan a neighbor row, push the right end of each open run
            ST_SCAN:
            begin
                prev_edge_next = edge_hit;
                if (edge_hit && !prev_edge_reg)
                begin
                    push_en = 1'b1;
                    push_x  = XW'(cur_reg - 1'b1);
                end
                if (cur_reg[XW-1:0] == hi_reg)
                begin
                    if (!edge_hit)
                    begin
                        push_en = 1'b1;
                        push_x  = hi_reg;
                    end
                    if (below_reg)
                    begin
                        state_next = ST_POP;
                    end
                    else
                    begin
                        below_next = 1'b1;
                        state_next = ST_NEXT_ROW;
                    end
                end
                else
                begin
                    cur_next    = cur_reg + 1'b1;
                    frame_re    = 1'b1;
                    frame_raddr = {scan_y_reg, XW'(cur_reg + 1'b1)};
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // right painting starts one past the seed
        if (start_right)
        begin
            if (right_first >= win_w)
            begin
                hi_next    = seed_x_reg;
                below_next = 1'b0;
                state_next = ST_NEXT_ROW;
            end
            else
            begin
                cur_next    = right_first;
                frame_re    = 1'b1;
                frame_raddr = {row_reg, right_first[XW-1:0]};
                state_next  = ST_RIGHT;
            end
        end
    end

    // Seed push: drop and flag on a full stack
    always_comb
    begin
        stack_we    = 1'b0;
        stack_waddr = SAW'(level_next_base());
        stack_wdata = {push_y, push_x};
        if (push_en && (level_next_base() != LW'(STACK_DEPTH)))
        begin
            stack_we = 1'b1;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_pend_reg <= 1'b0;
            level_reg     <= '0;
            ovf_reg       <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_pend_reg <= done_pend_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (push_en)
            begin
                if (level_next_base() == LW'(STACK_DEPTH))
                begin
                    level_reg <= level_next;
                    ovf_reg   <= 1'b1;
                end
                else
                begin
                    level_reg <= level_next_base() + 1'b1;
                    ovf_reg   <= ovf_next;
                end
            end
            else
            begin
                level_reg <= level_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        seed_x_reg    <= seed_x_next;
        row_reg       <= row_next;
        scan_y_reg    <= scan_y_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        below_reg     <= below_next;
        prev_edge_reg <= prev_edge_next;
        m_pix_reg     <= m_pix_next;
        m_done_reg    <= m_done_next;
        m_ovf_reg     <= m_ovf_next;
    end

endmodule

// File: rtl/core/scanline_seed_fill_core.sv
// ----------------------------------------------------------------------------
// scanline_seed_fill_core
// Frame buffer with a stack-based scanline seed fill.
// ----------------------------------------------------------------------------
// A pixel write inside the window goes to the frame RAM as it is accepted
// and gives no result; a pixel read inside the window goes through one
// frame RAM read and then the output register. A fill holds the input side
// until its walk ends and its result is taken: with one frame RAM read in
// flight at a time, the walk paints pixels and scans neighbor pixels, and
// each popped seed adds the pop, the stack read, the two color stops and
// row selection. The frame and seed stack RAMs are not cleared: reading a
// never-written pixel returns whatever the RAM holds.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scanline_seed_fill_core #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int STACK_DEPTH = 1024,
    parameter int PIXEL_BITS  = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pos_x[7:0], pos_y[15:8], write_pixel[47:16]
    input  logic [scsf_pkg::S_TDATA_W-1:0]    s_tdata,
    // opcode[1:0]
    input  logic [scsf_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // read_pixel[31:0], stack_overflow[32], zero[39:33]
    output logic [scsf_pkg::M_TDATA_W-1:0]    m_tdata,
    // fill_done[0]
    output logic                              m_tuser,
    input  logic                              cfg_we,
    input  logic [scsf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [scsf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import scsf_pkg::*;

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int LW  = $clog2(STACK_DEPTH + 1);
    localparam int CWW = (XW + 1 > DIM_W) ? XW + 1 : DIM_W;
    localparam int CHW = (YW + 1 > DIM_W) ? YW + 1 : DIM_W;

    logic [CFG_DATA_W-1:0] fill_color_reg;
    logic [DIM_W-1:0]      active_width_reg;
    logic [DIM_W-1:0]      active_height_reg;
    logic [XW:0]           win_w;
    logic [YW:0]           win_h;

    logic                  frame_we, frame_re;
    logic [YW+XW-1:0]      frame_waddr, frame_raddr;
    logic [PIXEL_BITS-1:0] frame_wdata, frame_rdata;
    logic                  stack_we, stack_re;
    logic [SAW-1:0]        stack_waddr, stack_raddr;
    logic [YW+XW-1:0]      stack_wdata, stack_rdata;
    logic [LW-1:0]         stack_level;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_color_reg    <= '0;
            active_width_reg  <= DIM_W'(256);
            active_height_reg <= DIM_W'(256);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FILL_COLOR:    fill_color_reg    <= cfg_data;
                REG_ACTIVE_WIDTH:  active_width_reg  <= cfg_data[DIM_W-1:0];
                REG_ACTIVE_HEIGHT: active_height_reg <= cfg_data[DIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Window size clamped to 1..MAX
    always_comb
    begin
        if (active_width_reg == '0)
            win_w = (XW+1)'(1);
        else if (CWW'(active_width_reg) > CWW'(MAX_WIDTH))
            win_w = (XW+1)'(MAX_WIDTH);
        else
            win_w = (XW+1)'(active_width_reg);

        if (active_height_reg == '0)
            win_h = (YW+1)'(1);
        else if (CHW'(active_height_reg) > CHW'(MAX_HEIGHT))
            win_h = (YW+1)'(MAX_HEIGHT);
        else
            win_h = (YW+1)'(active_height_reg);
    end

    scsf_ram #(
        .AW (YW + XW),
        .DW (PIXEL_BITS)
    ) u_frame_ram (
        .clk   (clk),
        .we    (frame_we),
        .waddr (frame_waddr),
        .wdata (frame_wdata),
        .re    (frame_re),
        .raddr (frame_raddr),
        .rdata (frame_rdata)
    );

    scsf_ram #(
        .AW (SAW),
        .DW (YW + XW)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .re    (stack_re),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    scsf_fill_engine #(
        .XW          (XW),
        .YW          (YW),
        .PIXEL_BITS  (PIXEL_BITS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fill_color  (fill_color_reg[PIXEL_BITS-1:0]),
        .win_w       (win_w),
        .win_h       (win_h),
        .frame_we    (frame_we),
        .frame_waddr (frame_waddr),
        .frame_wdata (frame_wdata),
        .frame_re    (frame_re),
        .frame_raddr (frame_raddr),
        .frame_rdata (frame_rdata),
        .stack_we    (stack_we),
        .stack_waddr (stack_waddr),
        .stack_wdata (stack_wdata),
        .stack_re    (stack_re),
        .stack_raddr (stack_raddr),
        .stack_rdata (stack_rdata),
        .stack_level (stack_level)
    );

    // Checks
    `SCSF_ASSERT(a_ready_needs_out_room, !s_tready || !m_tvalid || m_tready, "ready while output blocked")
    `SCSF_ASSERT(a_level_bound, stack_level <= LW'(STACK_DEPTH), "stack level past depth")
    `SCSF_ASSERT(a_idle_stack_empty, !s_tready || (stack_level == '0), "ready with seeds left")
    `SCSF_ASSERT_NEXT(a_write_no_result, s_tvalid && s_tready && (s_tuser == OP_WRITE) && !m_tvalid, !m_tvalid, "write beat produced a result")

endmodule
